### src/rsr_pkg.sv
// rsr_pkg: shared types and constants for the radar sweep ring renderer
// depends on nothing; used by every module of the block
package rsr_pkg;

  // sweep timing and colors
  localparam int PERIOD_NUM  = 2000;
  localparam int PING_START  = 200;
  localparam int PING_FADE   = 10;
  localparam int HEAD_RED    = 150;
  localparam int HEAD_GREEN  = 255;
  localparam int HEAD_BLUE   = 150;

  // iterative divider: dividend width
  localparam int DIV_W       = 14;
  // tail shading: quotient bits, pipeline stages in the back end
  localparam int Q_BITS      = 8;
  localparam int BACK_STAGES = Q_BITS + 2;

  // frame queue depth
  localparam int FIFO_DEPTH  = 2;

  // request modes
  localparam logic MODE_TRIGGER = 1'b0;
  localparam logic MODE_RENDER  = 1'b1;

  // register indexes
  localparam logic [0:0] REG_REF_LEDS    = 1'b0;
  localparam logic [0:0] REG_ROUND_LIMIT = 1'b1;

  typedef enum logic [2:0] {
    F_IDLE,
    F_EVAL,
    F_DIV_PER,
    F_STEP,
    F_SCALE,
    F_DIV_POS,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [6:0]           divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_W-1:0]     quotient;
  } div_rsp_t;

  // one frame handed from front to back
  typedef struct packed {
    logic [6:0]  n;
    logic [6:0]  spos;
    logic [4:0]  tail;
    logic [7:0]  ping;
    logic [31:0] next_due;
  } frame_t;

  // one led in flight through the shading pipeline
  typedef struct packed {
    logic        vld;
    logic [6:0]  k;
    logic        last;
    logic        is_head;
    logic        in_tail;
    logic [4:0]  inv;
    logic [4:0]  tail;
    logic [7:0]  ping;
    logic [31:0] next_due;
    logic [17:0] rem;
    logic [9:0]  den;
    logic [Q_BITS-1:0] quo;
  } slot_t;

endpackage

### src/radar_sweep_led_ring_renderer_core.sv
// radar_sweep_led_ring_renderer_core: top level of the radar sweep renderer
// uses rsr_pkg, rsr_div, rsr_front, rsr_fifo and rsr_back
//
// usage
// - input channel (in_valid/in_ready): in_mode 0 is a trigger request that
//   restarts the sweep at in_now_ms; in_mode 1 renders one frame of a ring of
//   in_leds_in_ring leds. a frame gives one output request per led, in order,
//   with out_last_led on the final one and the same out_next_due_ms in all
// - config port: cfg_we, cfg_index 0 writes ref_leds, 1 writes round_limit;
//   no read-back; user must write only while the block is idle (unchecked)
// - front end: a trigger or a dropped frame runs no divide, a frame of an
//   empty ring only the step-period divide and a frame two serial divides
//   (step period, then head scaling); the front hands the frame to a 2-deep
//   queue and takes the next request
// - the back end emits one led per cycle while out_ready does not stall it,
//   through a 10-stage shading pipeline (issue stage, square stage, then one
//   quotient bit per stage); it pops a frame only after the last led of the
//   previous one is issued, so the front divides bound the frame rate for
//   small rings and the led walk for large ones
// - reset (rst_n low, synchronous) stops the sweep, empties queue and
//   pipeline, and loads ref_leds 60 and round_limit 3
// - out_ready low with out_valid high freezes the whole shading pipeline,
//   output held; the front keeps working until the queue fills
module radar_sweep_led_ring_renderer_core #(
  parameter int MAX_LEDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [31:0] in_now_ms,
  input  logic [6:0]  in_leds_in_ring,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_led_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last_led,
  output logic [31:0] out_next_due_ms,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import rsr_pkg::*;

  // divider shared by the period and head-scaling divides
  div_req_t div_req;
  div_rsp_t div_rsp;

  // frame queue hookup
  frame_t push_data;
  frame_t pop_data;
  logic   push;
  logic   pop;
  logic   fifo_full;
  logic   fifo_empty;

  rsr_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // front end: sweep state, step scheduling, head scaling
  rsr_front #(
    .MAX_LEDS (MAX_LEDS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_now_ms       (in_now_ms),
    .in_leds_in_ring (in_leds_in_ring),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .div_req         (div_req),
    .div_rsp         (div_rsp),
    .push            (push),
    .push_data       (push_data),
    .fifo_full       (fifo_full)
  );

  // decouples frame setup from the led walk
  rsr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (fifo_empty)
  );

  // back end: per-led shading and output register
  rsr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_data       (pop_data),
    .fifo_empty      (fifo_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_led_index   (out_led_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_led    (out_last_led),
    .out_next_due_ms (out_next_due_ms)
  );

endmodule

### src/rsr_div.sv
// rsr_div: restoring divider, one quotient bit per cycle
// uses rsr_pkg for the request and response structs
module rsr_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rsr_pkg::div_req_t req,
  output rsr_pkg::div_rsp_t rsp
);
  import rsr_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [6:0]       rem_r;
  logic [DIV_W-1:0] acc_r;
  logic [6:0]       dvs_r;

  logic [7:0] trial;
  logic [7:0] diff;
  logic       ge;

  assign trial = {rem_r, acc_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[6:0] : trial[6:0];
      acc_r <= {acc_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = acc_r;

endmodule

### src/rsr_front.sv
// rsr_front: accepts requests, holds the sweep state and config registers,
// schedules head steps and scales the head onto the ring; uses rsr_pkg
module rsr_front #(
  parameter int MAX_LEDS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [31:0]       in_now_ms,
  input  logic [6:0]        in_leds_in_ring,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  output rsr_pkg::div_req_t div_req,
  input  rsr_pkg::div_rsp_t div_rsp,
  output logic              push,
  output rsr_pkg::frame_t   push_data,
  input  logic              fifo_full
);
  import rsr_pkg::*;

  front_state_t state_r, state_nxt;

  logic [6:0]  ref_leds_r;
  logic [7:0]  round_limit_r;
  logic        running_r;
  logic [31:0] last_step_r;
  logic [6:0]  head_r;
  logic [7:0]  rounds_r;
  logic [7:0]  ping_r;

  logic        mode_r;
  logic [31:0] now_r;
  logic [6:0]  n_r;
  logic [10:0] period_r;
  logic [6:0]  spos_r;

  logic [6:0]  ref_c;
  logic [6:0]  n_c;
  logic        limit_hit;
  logic        render_go;
  logic        step_due;
  logic [6:0]  head_inc;
  logic        head_wrap;
  logic [6:0]  head_new;
  logic [7:0]  ping_new;

  // clamp counts into the supported range
  always_comb begin
    if (ref_leds_r == 7'd0) begin
      ref_c = 7'd1;
    end else if (int'(ref_leds_r) > MAX_LEDS) begin
      ref_c = 7'(MAX_LEDS);
    end else begin
      ref_c = ref_leds_r;
    end
    if (int'(n_r) > MAX_LEDS) begin
      n_c = 7'(MAX_LEDS);
    end else begin
      n_c = n_r;
    end
  end

  assign limit_hit = rounds_r >= round_limit_r;
  assign render_go = (mode_r == MODE_RENDER) && running_r && !limit_hit;
  assign step_due  = (now_r - last_step_r) >= {21'b0, period_r};
  assign head_inc  = head_r + 7'd1;
  assign head_wrap = head_inc >= ref_c;
  assign head_new  = head_wrap ? 7'd0 : head_inc;

  always_comb begin
    if (head_new == 7'd1) begin
      ping_new = 8'(PING_START);
    end else if (ping_r >= 8'(PING_FADE)) begin
      ping_new = ping_r - 8'(PING_FADE);
    end else begin
      ping_new = 8'd0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:    if (in_valid) state_nxt = F_EVAL;
      F_EVAL:    state_nxt = render_go ? F_DIV_PER : F_IDLE;
      F_DIV_PER: if (div_rsp.done) state_nxt = F_STEP;
      F_STEP:    state_nxt = (n_c == 7'd0) ? F_IDLE : F_SCALE;
      F_SCALE:   state_nxt = F_DIV_POS;
      F_DIV_POS: if (div_rsp.done) state_nxt = F_PUSH;
      F_PUSH:    if (!fifo_full) state_nxt = F_IDLE;
      default:   state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = 1'b0;
    push             = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(PERIOD_NUM);
    div_req.divisor  = ref_c;
    case (state_r)
      F_IDLE:  in_ready = 1'b1;
      F_EVAL:  div_req.start = render_go;
      F_SCALE: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(head_r * n_c);
      end
      F_PUSH:  push = !fifo_full;
      default: ;
    endcase
  end

  assign push_data.n        = n_c;
  assign push_data.spos     = spos_r;
  assign push_data.tail     = n_c[6:2];
  assign push_data.ping     = ping_r;
  assign push_data.next_due = last_step_r + {21'b0, period_r};

  // control and sweep state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= F_IDLE;
      ref_leds_r    <= 7'd60;
      round_limit_r <= 8'd3;
      running_r     <= 1'b0;
      last_step_r   <= '0;
      head_r        <= '0;
      rounds_r      <= '0;
      ping_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_REF_LEDS:    ref_leds_r    <= cfg_wdata[6:0];
          REG_ROUND_LIMIT: round_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == F_EVAL) begin
        if (mode_r == MODE_TRIGGER) begin
          running_r   <= 1'b1;
          last_step_r <= now_r;
          head_r      <= '0;
          rounds_r    <= '0;
          ping_r      <= '0;
        end else if (running_r && limit_hit) begin
          running_r <= 1'b0;
        end
      end
      if (state_r == F_STEP && step_due) begin
        last_step_r <= last_step_r + {21'b0, period_r};
        head_r      <= head_new;
        ping_r      <= ping_new;
        if (head_wrap) rounds_r <= rounds_r + 8'd1;
      end
    end
  end

  // request payload and divider results
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      mode_r <= in_mode;
      now_r  <= in_now_ms;
      n_r    <= in_leds_in_ring;
    end
    if (state_r == F_DIV_PER && div_rsp.done) begin
      period_r <= div_rsp.quotient[10:0];
    end
    if (state_r == F_DIV_POS && div_rsp.done) begin
      // head past the ring sticks to the last led
      if (div_rsp.quotient >= DIV_W'(n_c)) begin
        spos_r <= n_c - 7'd1;
      end else begin
        spos_r <= div_rsp.quotient[6:0];
      end
    end
  end

endmodule

### src/rsr_fifo.sv
// rsr_fifo: short frame queue between front and back ends
// uses rsr_pkg for the frame type and depth
module rsr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rsr_pkg::frame_t push_data,
  output logic            full,
  input  logic            pop,
  output rsr_pkg::frame_t pop_data,
  output logic            empty
);
  import rsr_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  frame_t           mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = cnt_r == CNT_W'(FIFO_DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

### src/rsr_back.sv
// rsr_back: walks the leds of each queued frame and shades them through
// a square stage and a bit-per-stage divider pipeline; uses rsr_pkg
module rsr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rsr_pkg::frame_t fifo_data,
  input  logic            fifo_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [5:0]      out_led_index,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic            out_last_led,
  output logic [31:0]     out_next_due_ms
);
  import rsr_pkg::*;

  frame_t     cur_r;
  logic       busy_r;
  logic [6:0] k_r;

  slot_t st_r   [BACK_STAGES];
  slot_t st_nxt [BACK_STAGES];
  slot_t iss;
  slot_t tail_s;

  logic       adv;
  logic       issue;
  logic [7:0] d_wide;
  logic [6:0] d;
  logic [9:0] sq;

  assign tail_s = st_r[BACK_STAGES-1];
  assign adv    = !tail_s.vld || out_ready;
  assign issue  = busy_r && adv;
  assign pop    = !busy_r && !fifo_empty;

  // distance behind the head, wrapping round the ring
  always_comb begin
    if (cur_r.spos >= k_r) begin
      d_wide = {1'b0, cur_r.spos} - {1'b0, k_r};
    end else begin
      d_wide = {1'b0, cur_r.spos} + {1'b0, cur_r.n} - {1'b0, k_r};
    end
    d = d_wide[6:0];
  end

  always_comb begin
    iss          = '0;
    iss.vld      = issue;
    iss.k        = k_r;
    iss.last     = k_r == cur_r.n - 7'd1;
    iss.is_head  = k_r == cur_r.spos;
    iss.in_tail  = d < {2'b0, cur_r.tail};
    iss.inv      = cur_r.tail - d[4:0];
    iss.tail     = cur_r.tail;
    iss.ping     = cur_r.ping;
    iss.next_due = cur_r.next_due;
  end

  assign sq = 10'(st_r[0].inv) * 10'(st_r[0].inv);

  always_comb begin
    st_nxt[0] = iss;
    // 255 * inv^2 over tail^2
    st_nxt[1]     = st_r[0];
    st_nxt[1].rem = {sq, 8'b0} - {8'b0, sq};
    st_nxt[1].den = 10'(st_r[0].tail) * 10'(st_r[0].tail);
    st_nxt[1].quo = '0;
    for (int i = 1; i < BACK_STAGES - 1; i++) begin
      st_nxt[i+1] = st_r[i];
      if (st_r[i].rem >= (18'(st_r[i].den) << (Q_BITS - i))) begin
        st_nxt[i+1].rem = st_r[i].rem - (18'(st_r[i].den) << (Q_BITS - i));
        st_nxt[i+1].quo[Q_BITS-i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BACK_STAGES; i++) st_r[i] <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      k_r    <= '0;
    end else if (issue) begin
      k_r <= k_r + 7'd1;
      if (k_r == cur_r.n - 7'd1) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= fifo_data;
  end

  assign out_valid       = tail_s.vld;
  assign out_led_index   = tail_s.k[5:0];
  assign out_last_led    = tail_s.last;
  assign out_next_due_ms = tail_s.next_due;

  always_comb begin
    if (tail_s.is_head) begin
      out_red   = 8'(HEAD_RED);
      out_green = 8'(HEAD_GREEN);
      out_blue  = 8'(HEAD_BLUE);
    end else if (tail_s.in_tail) begin
      out_red   = 8'd0;
      out_green = tail_s.quo;
      out_blue  = 8'd0;
    end else begin
      out_red   = 8'd0;
      out_green = tail_s.ping;
      out_blue  = 8'd0;
    end
  end

endmodule

### tb/radar_sweep_led_ring_renderer_core_tb.sv
// radar_sweep_led_ring_renderer_core_tb: self-checking bench for the radar sweep ring renderer
// holds a per-led color predictor class and the bench top; needs rsr_pkg and the core rtl

module radar_sweep_led_ring_renderer_core_tb;
  import rsr_pkg::*;

  // one led color as it leaves the output channel
  typedef struct packed {
    logic [5:0]  idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_led;
    logic [31:0] next_due;
  } led_color_t;

  class ring_color_predictor;
    int unsigned ring_max;
    logic [6:0]  ref_leds;
    logic [7:0]  round_limit;
    bit          running;
    logic [31:0] last_step;
    int unsigned head_pos;
    int unsigned rounds_done;
    int unsigned ping_level;
    led_color_t  pending_leds[$];
    int unsigned errors;
    int unsigned leds_checked;
    int unsigned sweeps;
    int unsigned stops;

    function new(int unsigned max_leds);
      ring_max     = max_leds;
      ref_leds     = 7'd60;
      round_limit  = 8'd3;
      running      = 1'b0;
      last_step    = '0;
      head_pos     = 0;
      rounds_done  = 0;
      ping_level   = 0;
      errors       = 0;
      leds_checked = 0;
      sweeps       = 0;
      stops        = 0;
    endfunction

    function void write_reg(logic [0:0] index, logic [7:0] value);
      if (index == REG_REF_LEDS) ref_leds = value[6:0];
      else round_limit = value;
    endfunction

    // reference count as the block uses it
    function int unsigned ref_count();
      if (ref_leds == 0) return 1;
      if (ref_leds > ring_max) return ring_max;
      return ref_leds;
    endfunction

    function int unsigned period_ms();
      return PERIOD_NUM / ref_count();
    endfunction

    // returns 1 when the request did anything beyond being ignored
    function bit accept_request(logic mode, logic [31:0] now, logic [6:0] n_in);
      int unsigned ref_n, period, ring, spos, tail, d, inv, k;
      logic [31:0] elapsed, next_due;
      led_color_t  led;
      if (mode == MODE_TRIGGER) begin
        running     = 1'b1;
        last_step   = now;
        head_pos    = 0;
        rounds_done = 0;
        ping_level  = 0;
        sweeps++;
        return 1'b1;
      end
      if (!running) return 1'b0;
      if (rounds_done >= round_limit) begin
        running = 1'b0;
        stops++;
        return 1'b1;
      end
      ref_n   = ref_count();
      period  = PERIOD_NUM / ref_n;
      elapsed = now - last_step;
      if (elapsed >= period) begin
        last_step = last_step + period;
        head_pos  = (head_pos + 1) & 8'hff;
        if (head_pos >= ref_n) begin
          head_pos    = 0;
          rounds_done = (rounds_done + 1) & 8'hff;
        end
        if (head_pos == 1) ping_level = PING_START;
        else ping_level = (ping_level >= PING_FADE) ? ping_level - PING_FADE : 0;
      end
      next_due = last_step + period;
      if (n_in == 0) return 1'b1;
      ring = (n_in > ring_max) ? ring_max : n_in;
      spos = head_pos * ring / ref_n;
      if (spos >= ring) spos = ring - 1;
      tail = ring / 4;
      for (k = 0; k < ring; k++) begin
        d            = (spos >= k) ? spos - k : spos + ring - k;
        led.idx      = k[5:0];
        led.red      = '0;
        led.green    = ping_level[7:0];
        led.blue     = '0;
        led.last_led = (k == ring - 1);
        led.next_due = next_due;
        if (k == spos) begin
          led.red   = 8'(HEAD_RED);
          led.green = 8'(HEAD_GREEN);
          led.blue  = 8'(HEAD_BLUE);
        end else if (d < tail) begin
          inv       = tail - d;
          led.green = 8'((255 * inv * inv) / (tail * tail));
        end
        pending_leds.push_back(led);
      end
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_led(led_color_t got);
      led_color_t want;
      if (pending_leds.size() == 0) begin
        $display("%0t: unexpected led, expected none, actual index %0d", $time, got.idx);
        errors++;
        return;
      end
      want = pending_leds.pop_front();
      leds_checked++;
      compare_field("led_index", want.idx, got.idx);
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("last_led", want.last_led, got.last_led);
      compare_field("next_due_ms", want.next_due, got.next_due);
    endfunction
  endclass

  localparam int RING_MAX      = 64;
  localparam int RANDOM_ITEMS  = 500;
  localparam int SETTLE_CYCLES = 200;

  // ring sizes of the directed stepping run: full ring, empty, oversize, tiny, no tail
  localparam logic [6:0] DIRECTED_SIZES [7] = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd4, 7'd3, 7'd60};
  // first random phases sweep the register extremes, bit 7 of ref data is don't-care
  localparam logic [7:0] FIRST_REFS [5]   = '{8'd64, 8'h81, 8'h00, 8'h7f, 8'd3};
  localparam logic [7:0] FIRST_LIMITS [5] = '{8'd255, 8'd1, 8'd3, 8'd0, 8'd2};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_mode;
  logic [31:0] in_now_ms;
  logic [6:0]  in_leds_in_ring;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_led_index;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_last_led;
  logic [31:0] out_next_due_ms;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  // steady turns off idling on both sides for a whole phase
  bit                  steady;
  ring_color_predictor model;
  int unsigned         requests;
  int unsigned         handled;
  int unsigned         settings;

  radar_sweep_led_ring_renderer_core #(
    .MAX_LEDS(RING_MAX)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_now_ms      (in_now_ms),
    .in_leds_in_ring(in_leds_in_ring),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_led_index  (out_led_index),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_last_led   (out_last_led),
    .out_next_due_ms(out_next_due_ms),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // receiver stalls about 35 percent of the time unless the phase is steady
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 35);
  end

  // every accepted led is checked against the oldest predicted one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      model.check_led(led_color_t'({out_led_index, out_red, out_green, out_blue,
                                    out_last_led, out_next_due_ms}));
  end

  // one request on the input channel; entered and left at a falling edge
  task automatic send_request(logic mode, logic [31:0] now, logic [6:0] n);
    int unsigned gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 35) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_now_ms       <= now;
    in_leds_in_ring <= n;
    do @(posedge clk); while (!in_ready);
    requests++;
    if (model.accept_request(mode, now, n)) handled++;
    @(negedge clk);
  endtask

  // wait for every predicted led, then let requests without leds drain out of the front end
  task automatic settle();
    in_valid <= 1'b0;
    while (model.pending_leds.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // both registers, back to back, only while the block is idle
  task automatic write_settings(logic [7:0] ref_data, logic [7:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REF_LEDS;
    cfg_wdata <= ref_data;
    @(posedge clk) model.write_reg(REG_REF_LEDS, ref_data);
    @(negedge clk);
    cfg_index <= REG_ROUND_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk) model.write_reg(REG_ROUND_LIMIT, limit);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // mostly well-formed sweeps: a trigger, then frames timed around the step period
  task automatic random_phase(int unsigned items);
    int unsigned i, period, pick;
    logic [31:0] now;
    logic [6:0]  n;
    for (i = 0; i < items; i++) begin
      period = model.period_ms();
      pick   = $urandom_range(99);
      if (pick < 10) begin
        // noise: any mode, any time, any size
        send_request(1'($urandom_range(1)), $urandom, 7'($urandom_range(127)));
      end else if (!model.running || pick < 16) begin
        send_request(MODE_TRIGGER, $urandom, 7'($urandom_range(127)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 40) now = model.last_step + period;
        else if (pick < 55) now = model.last_step + period - 1;
        else if (pick < 65) now = model.last_step;
        else if (pick < 90) now = model.last_step + $urandom_range(3 * period);
        else now = model.last_step + $urandom_range(200000);
        pick = $urandom_range(99);
        if (pick < 65) n = 7'($urandom_range(1, 16));
        else if (pick < 82) n = 7'($urandom_range(17, RING_MAX));
        else if (pick < 90) n = 7'($urandom_range(RING_MAX + 1, 127));
        else if (pick < 95) n = 7'd0;
        else n = model.ref_leds;
        send_request(MODE_RENDER, now, n);
      end
    end
  endtask

  initial begin
    logic [31:0] t;
    logic [7:0]  ref_data, limit;
    int unsigned phase, base, pick;
    int          k;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = MODE_TRIGGER;
    in_now_ms       = '0;
    in_leds_in_ring = '0;
    cfg_we          = 1'b0;
    cfg_index       = REG_REF_LEDS;
    cfg_wdata       = '0;
    steady          = 1'b0;
    requests        = 0;
    handled         = 0;
    settings        = 0;
    model           = new(RING_MAX);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset settings: frame before any trigger is dropped
    send_request(MODE_RENDER, 32'd100, 7'd8);
    // trigger just below the wrap, first frame one ms short of a step
    send_request(MODE_TRIGGER, 32'hffff_fff0, 7'd8);
    send_request(MODE_RENDER, 32'h0000_0010, 7'd8);
    // frames exactly one period apart, head reaches the ping position first
    t = 32'h0000_0011;
    for (k = 0; k < 7; k++) begin
      send_request(MODE_RENDER, t, DIRECTED_SIZES[k]);
      t = t + model.period_ms();
    end
    // late frames catch up one step each
    send_request(MODE_RENDER, t + 1000, 7'd7);
    send_request(MODE_RENDER, t + 1000, 7'd9);
    settle();

    // smaller reference ring mid-sweep leaves the head past the ring
    write_settings({1'b1, 7'd4}, 8'd2);
    send_request(MODE_RENDER, model.last_step + 10, 7'd16);
    // step through two rounds until the sweep stops itself, then one dropped frame
    for (k = 0; k < 7; k++)
      send_request(MODE_RENDER, model.last_step + model.period_ms(), 7'(5 + k));
    settle();

    // round limit zero stops at the first frame
    write_settings(8'd1, 8'd0);
    send_request(MODE_TRIGGER, $urandom, 7'd0);
    send_request(MODE_RENDER, $urandom, 7'd12);
    settle();

    // random sweeps under changing settings
    base  = handled;
    phase = 0;
    while (handled - base < RANDOM_ITEMS) begin
      if (phase < 5) begin
        ref_data = FIRST_REFS[phase];
        limit    = FIRST_LIMITS[phase];
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) ref_data = {1'($urandom_range(1)), 7'($urandom_range(1, 8))};
        else ref_data = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 50) limit = 8'($urandom_range(1, 3));
        else if (pick < 60) limit = 8'd0;
        else if (pick < 70) limit = 8'd255;
        else limit = 8'($urandom_range(255));
      end
      steady = (phase == 2);
      write_settings(ref_data, limit);
      random_phase($urandom_range(30, 60));
      settle();
      phase++;
    end
    steady = 1'b0;

    $display("summary: %0d requests, %0d leds checked, %0d sweeps started, %0d self stops",
             requests, model.leds_checked, model.sweeps, model.stops);
    $display("summary: %0d register settings over %0d random phases", settings, phase);
    if (model.errors == 0 && model.pending_leds.size() == 0) begin
      $display("[radar_sweep_led_ring_renderer_core] OK");
    end else begin
      $display("%0t: %0d mismatches, %0d leds never seen", $time, model.errors,
               model.pending_leds.size());
      $display("[radar_sweep_led_ring_renderer_core] ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("[radar_sweep_led_ring_renderer_core] ERROR");
    $finish;
  end

endmodule

### sim.f
src/rsr_pkg.sv
src/rsr_div.sv
src/rsr_front.sv
src/rsr_fifo.sv
src/rsr_back.sv
src/radar_sweep_led_ring_renderer_core.sv
tb/radar_sweep_led_ring_renderer_core_tb.sv
